// File: rtl/lahr_pkg.sv
// Shared constants, types and selection functions of the lookahead route compute block.
`timescale 1ns / 1ps

package lahr_pkg;

  // Sizing of the routing tables.
  localparam int NUM_PORTS    = 8;
  localparam int NUM_NODES    = 64;
  localparam int WEIGHT_LIMIT = 10000;
  localparam int NEXT_DEPTH   = 8;

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int PORT_W   = 3;
  localparam int ENTRY_W  = 3;
  localparam int MASK_W   = 64;
  localparam int WEIGHT_W = 14;
  localparam int CNT_W    = 4;
  localparam int VC_W     = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  // Internal widths derived from the table sizes.
  localparam int SEL_W  = $clog2(NUM_PORTS);
  localparam int NSEL_W = $clog2(NEXT_DEPTH);
  localparam int PCNT_W = $clog2(NUM_PORTS + 1);

  localparam logic [MASK_W-1:0] NODE_MASK = {MASK_W{1'b1}} >> (MASK_W - NUM_NODES);
  localparam logic [CFG_W-1:0]  ACTIVE_PORTS_RST = CFG_W'(NUM_PORTS);

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOCAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROUTE = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_LOCAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_NEXT  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PORT_W-1:0]   port;
    logic [ENTRY_W-1:0]  entry;
    logic [MASK_W-1:0]   mask;
    logic [WEIGHT_W-1:0] weight;
    logic [CNT_W-1:0]    count;
    logic [VC_W-1:0]     vc;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]   mask;
    logic [WEIGHT_W-1:0] weight;
  } next_ent_t;

  localparam int NENT_W = $bits(next_ent_t);

  typedef logic [NUM_PORTS-1:0][WEIGHT_W-1:0]  port_wt_t;
  typedef logic [NEXT_DEPTH-1:0][WEIGHT_W-1:0] entry_wt_t;

  typedef struct packed {
    logic             found;
    logic [SEL_W-1:0] idx;
  } port_pick_t;

  typedef struct packed {
    logic              found;
    logic [NSEL_W-1:0] idx;
  } entry_pick_t;

  // Lowest weight below the limit among the candidates; the lowest index wins a tie.
  function automatic port_pick_t pick_port(input logic [NUM_PORTS-1:0] cand,
                                           input port_wt_t wt);
    port_pick_t          r;
    logic [WEIGHT_W-1:0] best;
    r    = '0;
    best = WEIGHT_W'(WEIGHT_LIMIT);
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (cand[i] && (wt[i] < best)) begin
        best    = wt[i];
        r.idx   = SEL_W'(i);
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic entry_pick_t pick_entry(input logic [NEXT_DEPTH-1:0] cand,
                                             input entry_wt_t wt);
    entry_pick_t         r;
    logic [WEIGHT_W-1:0] best;
    r    = '0;
    best = WEIGHT_W'(WEIGHT_LIMIT);
    for (int i = 0; i < NEXT_DEPTH; i++) begin
      if (cand[i] && (wt[i] < best)) begin
        best    = wt[i];
        r.idx   = NSEL_W'(i);
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/lahr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module lahr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/lookahead_table_route_compute.sv
// Top level of the lookahead route compute unit: six-stage table lookup pipeline.
`timescale 1ns / 1ps

// Route compute with one hop of lookahead. Every input transfer carries one item and
// produces exactly one result transfer, in order. Items of mode 0, 1 and 2 load the
// local table (mask and weight per port), one next-hop entry, or the next-hop entry
// count of a port; they answer with status 0. A route item picks the lowest-weight
// active local port whose mask meets the destination mask (lowest index on a tie),
// then the lowest-weight matching entry of that port's next-hop table; weights at or
// above the limit never match. The pipeline has six register stages: input capture,
// local match, local selection, next-hop table read, next-hop match, and the result
// register. One item is taken every cycle as long as the result side keeps up; a
// stalled result holds the stages behind it only as far as they are full. The local
// table is read and written in the input capture stage and the next-hop tables and
// counts in the selection stage, so every item sees exactly the writes of the items
// taken before it. The next-hop table lives in one small RAM per entry index,
// addressed by port. The user must write active_ports through the configuration port
// only while no item is in flight; the block does not enforce this. Values outside 1
// to the port count are clamped.
module lookahead_table_route_compute (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lahr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lahr_pkg::MODE_W-1:0]    in_mode,
  input  logic [lahr_pkg::PORT_W-1:0]    in_port_index,
  input  logic [lahr_pkg::ENTRY_W-1:0]   in_entry_index,
  input  logic [lahr_pkg::MASK_W-1:0]    in_dest_mask,
  input  logic [lahr_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic [lahr_pkg::CNT_W-1:0]     in_entry_count,
  input  logic [lahr_pkg::VC_W-1:0]      in_vc_tag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lahr_pkg::PORT_W-1:0]    out_out_port,
  output logic [lahr_pkg::PORT_W-1:0]    out_next_port,
  output logic                           out_has_next,
  output logic [lahr_pkg::VC_W-1:0]      out_vc_echo,
  output logic [lahr_pkg::STATUS_W-1:0]  out_status
);

  // Configuration register.
  logic [lahr_pkg::CFG_W-1:0] active_ports_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ports_r <= lahr_pkg::ACTIVE_PORTS_RST;
    end else if (cfg_wr_en) begin
      active_ports_r <= cfg_wr_data;
    end
  end

  // Stage valid bits and load enables. A stage loads when it is empty or its
  // content moves on in the same cycle.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_v_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !out_v_r || out_ready;
  assign en5      = !s5_v_r || en6;
  assign en4      = !s4_v_r || en5;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r  <= in_valid;
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) s3_v_r  <= s2_v_r;
      if (en4) s4_v_r  <= s3_v_r;
      if (en5) s5_v_r  <= s4_v_r;
      if (en6) out_v_r <= s5_v_r;
    end
  end

  // Stage 1: input capture.
  lahr_pkg::item_t s1_item_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_item_r.mode   <= in_mode;
      s1_item_r.port   <= in_port_index;
      s1_item_r.entry  <= in_entry_index;
      s1_item_r.mask   <= in_dest_mask;
      s1_item_r.weight <= in_weight;
      s1_item_r.count  <= in_entry_count;
      s1_item_r.vc     <= in_vc_tag;
    end
  end

  // Local table, read and written only by the item in stage 1.
  logic [lahr_pkg::MASK_W-1:0]   loc_mask_r [lahr_pkg::NUM_PORTS];
  logic [lahr_pkg::WEIGHT_W-1:0] loc_wt_r   [lahr_pkg::NUM_PORTS];
  logic                          loc_wr;

  assign loc_wr = s1_v_r && en2 && (s1_item_r.mode == lahr_pkg::MODE_LOCAL);

  always_ff @(posedge clk) begin
    for (int p = 0; p < lahr_pkg::NUM_PORTS; p++) begin
      if (loc_wr && (int'(s1_item_r.port) == p)) begin
        loc_mask_r[p] <= s1_item_r.mask;
        loc_wt_r[p]   <= s1_item_r.weight;
      end
    end
  end

  // Active port count, clamped to 1 .. NUM_PORTS.
  logic [lahr_pkg::PCNT_W-1:0] ap_ext;
  logic [lahr_pkg::PCNT_W-1:0] ports_used;

  assign ap_ext = lahr_pkg::PCNT_W'(active_ports_r);

  always_comb begin
    if (ap_ext == '0) begin
      ports_used = lahr_pkg::PCNT_W'(1);
    end else if (ap_ext > lahr_pkg::PCNT_W'(lahr_pkg::NUM_PORTS)) begin
      ports_used = lahr_pkg::PCNT_W'(lahr_pkg::NUM_PORTS);
    end else begin
      ports_used = ap_ext;
    end
  end

  logic [lahr_pkg::NUM_PORTS-1:0] loc_cand_nxt;
  lahr_pkg::port_wt_t             loc_wt_nxt;

  always_comb begin
    for (int p = 0; p < lahr_pkg::NUM_PORTS; p++) begin
      loc_cand_nxt[p] = (|(s1_item_r.mask & lahr_pkg::NODE_MASK & loc_mask_r[p])) &&
                        (lahr_pkg::PCNT_W'(p) < ports_used);
      loc_wt_nxt[p]   = loc_wt_r[p];
    end
  end

  // Stage 2: local match results with a private copy of the weights, so that later
  // local writes cannot disturb this item.
  lahr_pkg::item_t                s2_item_r;
  logic [lahr_pkg::NUM_PORTS-1:0] s2_cand_r;
  lahr_pkg::port_wt_t             s2_wt_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_item_r <= s1_item_r;
      s2_cand_r <= loc_cand_nxt;
      s2_wt_r   <= loc_wt_nxt;
    end
  end

  lahr_pkg::port_pick_t loc_pick;

  assign loc_pick = lahr_pkg::pick_port(s2_cand_r, s2_wt_r);

  // Stage 3: chosen local port. Next-hop tables and counts are read and written here.
  lahr_pkg::item_t              s3_item_r;
  logic                         s3_found_r;
  logic [lahr_pkg::SEL_W-1:0]   s3_sel_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_item_r  <= s2_item_r;
      s3_found_r <= loc_pick.found;
      s3_sel_r   <= loc_pick.idx;
    end
  end

  logic                          s3_leave;
  logic                          s3_port_ok;
  logic                          nxt_wr;
  logic                          cnt_wr;
  logic [lahr_pkg::SEL_W-1:0]    nxt_wr_addr;
  lahr_pkg::next_ent_t           nxt_wr_data;
  logic [lahr_pkg::CNT_W-1:0]    cnt_sat;

  assign s3_leave    = s3_v_r && en4;
  assign s3_port_ok  = int'(s3_item_r.port) < lahr_pkg::NUM_PORTS;
  assign nxt_wr      = s3_leave && s3_port_ok && (s3_item_r.mode == lahr_pkg::MODE_NEXT);
  assign cnt_wr      = s3_leave && s3_port_ok && (s3_item_r.mode == lahr_pkg::MODE_COUNT);
  assign nxt_wr_addr = lahr_pkg::SEL_W'(s3_item_r.port);
  assign nxt_wr_data = '{mask: s3_item_r.mask, weight: s3_item_r.weight};
  assign cnt_sat     = (s3_item_r.count > lahr_pkg::CNT_W'(lahr_pkg::NEXT_DEPTH)) ?
                       lahr_pkg::CNT_W'(lahr_pkg::NEXT_DEPTH) : s3_item_r.count;

  // Next-hop entry counts; reset clears them so every port starts as an end node.
  logic [lahr_pkg::CNT_W-1:0] cnt_r [lahr_pkg::NUM_PORTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < lahr_pkg::NUM_PORTS; p++) begin
        cnt_r[p] <= '0;
      end
    end else if (cnt_wr) begin
      cnt_r[nxt_wr_addr] <= cnt_sat;
    end
  end

  // One RAM per next-hop entry index, addressed by port, so a route reads a whole
  // next-hop table in one access.
  lahr_pkg::next_ent_t ram_q [lahr_pkg::NEXT_DEPTH];

  for (genvar e = 0; e < lahr_pkg::NEXT_DEPTH; e++) begin : g_next
    logic ram_we;

    assign ram_we = nxt_wr && (int'(s3_item_r.entry) == e);

    lahr_ram #(
      .WIDTH (lahr_pkg::NENT_W),
      .DEPTH (lahr_pkg::NUM_PORTS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_we),
      .wr_addr (nxt_wr_addr),
      .wr_data (nxt_wr_data),
      .rd_en   (en4),
      .rd_addr (s3_sel_r),
      .rd_data (ram_q[e])
    );
  end

  // Stage 4: next-hop table of the chosen port (in the RAM output registers).
  lahr_pkg::item_t             s4_item_r;
  logic                        s4_found_r;
  logic [lahr_pkg::SEL_W-1:0]  s4_sel_r;
  logic [lahr_pkg::CNT_W-1:0]  s4_cnt_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_item_r  <= s3_item_r;
      s4_found_r <= s3_found_r;
      s4_sel_r   <= s3_sel_r;
      s4_cnt_r   <= cnt_r[s3_sel_r];
    end
  end

  logic [lahr_pkg::NEXT_DEPTH-1:0] nxt_cand_nxt;
  lahr_pkg::entry_wt_t             nxt_wt_nxt;

  always_comb begin
    for (int e = 0; e < lahr_pkg::NEXT_DEPTH; e++) begin
      nxt_cand_nxt[e] = (|(s4_item_r.mask & lahr_pkg::NODE_MASK & ram_q[e].mask)) &&
                        (lahr_pkg::CNT_W'(e) < s4_cnt_r);
      nxt_wt_nxt[e]   = ram_q[e].weight;
    end
  end

  // Stage 5: next-hop match results.
  logic [lahr_pkg::MODE_W-1:0]     s5_mode_r;
  logic [lahr_pkg::VC_W-1:0]       s5_vc_r;
  logic                            s5_found_r;
  logic [lahr_pkg::SEL_W-1:0]      s5_sel_r;
  logic                            s5_end_node_r;
  logic [lahr_pkg::NEXT_DEPTH-1:0] s5_cand_r;
  lahr_pkg::entry_wt_t             s5_wt_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_mode_r     <= s4_item_r.mode;
      s5_vc_r       <= s4_item_r.vc;
      s5_found_r    <= s4_found_r;
      s5_sel_r      <= s4_sel_r;
      s5_end_node_r <= (s4_cnt_r == '0);
      s5_cand_r     <= nxt_cand_nxt;
      s5_wt_r       <= nxt_wt_nxt;
    end
  end

  lahr_pkg::entry_pick_t          nxt_pick;
  logic [lahr_pkg::PORT_W-1:0]    port_nxt;
  logic [lahr_pkg::PORT_W-1:0]    nport_nxt;
  logic                           has_next_nxt;
  logic [lahr_pkg::STATUS_W-1:0]  status_nxt;

  assign nxt_pick = lahr_pkg::pick_entry(s5_cand_r, s5_wt_r);

  // Result formation: write items and failed local lookups report no ports.
  always_comb begin
    port_nxt     = '0;
    nport_nxt    = '0;
    has_next_nxt = 1'b0;
    status_nxt   = lahr_pkg::ST_OK;
    if (s5_mode_r == lahr_pkg::MODE_ROUTE) begin
      if (!s5_found_r) begin
        status_nxt = lahr_pkg::ST_NO_LOCAL;
      end else begin
        port_nxt = lahr_pkg::PORT_W'(s5_sel_r);
        if (nxt_pick.found) begin
          nport_nxt    = lahr_pkg::PORT_W'(nxt_pick.idx);
          has_next_nxt = 1'b1;
        end else if (!s5_end_node_r) begin
          status_nxt = lahr_pkg::ST_NO_NEXT;
        end
      end
    end
  end

  // Stage 6: result register.
  logic [lahr_pkg::PORT_W-1:0]    out_port_r;
  logic [lahr_pkg::PORT_W-1:0]    out_nport_r;
  logic                           out_has_next_r;
  logic [lahr_pkg::VC_W-1:0]      out_vc_r;
  logic [lahr_pkg::STATUS_W-1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      out_port_r     <= port_nxt;
      out_nport_r    <= nport_nxt;
      out_has_next_r <= has_next_nxt;
      out_vc_r       <= s5_vc_r;
      out_status_r   <= status_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_out_port  = out_port_r;
  assign out_next_port = out_nport_r;
  assign out_has_next  = out_has_next_r;
  assign out_vc_echo   = out_vc_r;
  assign out_status    = out_status_r;

endmodule

// File: rtl/lahr_checker.sv
// Port-level checker for the lookahead route compute unit, with its bind statement.
`timescale 1ns / 1ps

module lahr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lahr_pkg::PORT_W-1:0]    out_out_port,
  input logic [lahr_pkg::PORT_W-1:0]    out_next_port,
  input logic                           out_has_next,
  input logic [lahr_pkg::STATUS_W-1:0]  out_status
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // A next-hop port is only reported on a successful route.
  a_next_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_next |-> out_status == lahr_pkg::ST_OK)
    else $error("next-hop port reported with an error status");

  // Any failure clears the next-hop fields.
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lahr_pkg::ST_OK) |->
      !out_has_next && (out_next_port == '0))
    else $error("next-hop fields set on a failed route");

  // A missing local route reports port zero.
  a_no_local: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lahr_pkg::ST_NO_LOCAL) |-> out_out_port == '0)
    else $error("local port reported without a local route");

endmodule

bind lookahead_table_route_compute lahr_checker u_lahr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_out_port  (out_out_port),
  .out_next_port (out_next_port),
  .out_has_next  (out_has_next),
  .out_status    (out_status)
);

// File: tb/lookahead_table_route_compute_tb.sv
// Self-checking testbench for the lookahead table route compute unit.
`timescale 1ns / 1ps

// The testbench loads the local and next-hop tables, routes destination masks
// through them, and checks every result against its own model of the tables.
//
// A stimulus process fills a queue of pending items. A clocked driver moves
// them onto the input channel in bursts with random gaps. A clocked monitor
// predicts a result for every input transfer and compares each output
// transfer with the oldest prediction. The run goes through several phases,
// and each phase sets active_ports while the pipeline is empty and picks its
// own output stall pattern.
//
// Table entries that were never written must never be read by a route. The
// stimulus side therefore keeps track of what it has loaded. Before a route
// it loads any active local entry that is still missing. Before a count write
// it loads any next-hop entry below the new count that is still missing.
module lookahead_table_route_compute_tb;

  localparam int NUM_PHASES       = 9;
  localparam int RANDOM_PER_PHASE = 165;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MAX_REPORTS      = 100;

  typedef struct packed {
    logic [lahr_pkg::PORT_W-1:0]   port;
    logic [lahr_pkg::PORT_W-1:0]   nport;
    logic                          has_next;
    logic [lahr_pkg::VC_W-1:0]     vc;
    logic [lahr_pkg::STATUS_W-1:0] status;
  } route_result_t;

  // Clock, reset and every input of the block start from known values.
  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          cfg_wr_en      = 1'b0;
  logic [lahr_pkg::CFG_W-1:0]    cfg_wr_data    = '0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [lahr_pkg::MODE_W-1:0]   in_mode        = '0;
  logic [lahr_pkg::PORT_W-1:0]   in_port_index  = '0;
  logic [lahr_pkg::ENTRY_W-1:0]  in_entry_index = '0;
  logic [lahr_pkg::MASK_W-1:0]   in_dest_mask   = '0;
  logic [lahr_pkg::WEIGHT_W-1:0] in_weight      = '0;
  logic [lahr_pkg::CNT_W-1:0]    in_entry_count = '0;
  logic [lahr_pkg::VC_W-1:0]     in_vc_tag      = '0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [lahr_pkg::PORT_W-1:0]   out_out_port;
  logic [lahr_pkg::PORT_W-1:0]   out_next_port;
  logic                          out_has_next;
  logic [lahr_pkg::VC_W-1:0]     out_vc_echo;
  logic [lahr_pkg::STATUS_W-1:0] out_status;

  // Items waiting for the driver, and results predicted but not yet seen.
  lahr_pkg::item_t queued_items[$];
  route_result_t   predicted_results[$];

  // The monitor's copy of the block's tables and register.
  logic [lahr_pkg::MASK_W-1:0]   lt_mask   [lahr_pkg::NUM_PORTS];
  logic [lahr_pkg::WEIGHT_W-1:0] lt_weight [lahr_pkg::NUM_PORTS];
  logic [lahr_pkg::MASK_W-1:0]   nt_mask   [lahr_pkg::NUM_PORTS][lahr_pkg::NEXT_DEPTH];
  logic [lahr_pkg::WEIGHT_W-1:0] nt_weight [lahr_pkg::NUM_PORTS][lahr_pkg::NEXT_DEPTH];
  int                            nt_count  [lahr_pkg::NUM_PORTS];
  int                            act_ports;

  // What the stimulus side has loaded so far, so that no route reads an
  // entry that was never written.
  bit local_loaded [lahr_pkg::NUM_PORTS];
  bit next_loaded  [lahr_pkg::NUM_PORTS][lahr_pkg::NEXT_DEPTH];
  int gen_active;

  int errors       = 0;
  int stall_mode   = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int stall_phase  = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lookahead_table_route_compute i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_port_index  (in_port_index),
    .in_entry_index (in_entry_index),
    .in_dest_mask   (in_dest_mask),
    .in_weight      (in_weight),
    .in_entry_count (in_entry_count),
    .in_vc_tag      (in_vc_tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_port   (out_out_port),
    .out_next_port  (out_next_port),
    .out_has_next   (out_has_next),
    .out_vc_echo    (out_vc_echo),
    .out_status     (out_status)
  );

  // The block clamps active_ports to the range 1 to the port count.
  function automatic int clamp_ports(input logic [lahr_pkg::CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > lahr_pkg::NUM_PORTS) return lahr_pkg::NUM_PORTS;
    return int'(v);
  endfunction

  // Applies one item to the table copy and returns the result it should give.
  // Writes answer with status OK. A route first picks the lowest-weight active
  // local port whose mask meets the destination, then the lowest-weight
  // matching entry among that port's next-hop entries. Strict comparison
  // keeps the lowest index on a tie, and a weight at or above the limit can
  // never win.
  function automatic route_result_t compute_route(input lahr_pkg::item_t it);
    route_result_t                r;
    logic [lahr_pkg::MASK_W-1:0]  dest;
    logic [lahr_pkg::PORT_W-1:0]  sel;
    logic [lahr_pkg::ENTRY_W-1:0] nsel;
    logic                         found;
    logic                         found_n;
    int                           best;
    int                           n;
    r        = '0;
    r.vc     = it.vc;
    r.status = lahr_pkg::ST_OK;
    if (it.mode != lahr_pkg::MODE_ROUTE) begin
      if (int'(it.port) < lahr_pkg::NUM_PORTS) begin
        case (it.mode)
          lahr_pkg::MODE_LOCAL: begin
            lt_mask[it.port]   = it.mask;
            lt_weight[it.port] = it.weight;
          end
          lahr_pkg::MODE_NEXT: begin
            nt_mask[it.port][it.entry]   = it.mask;
            nt_weight[it.port][it.entry] = it.weight;
          end
          default: begin
            nt_count[it.port] = (it.count > lahr_pkg::NEXT_DEPTH) ?
                                lahr_pkg::NEXT_DEPTH : int'(it.count);
          end
        endcase
      end
      return r;
    end

    dest  = it.mask & lahr_pkg::NODE_MASK;
    best  = lahr_pkg::WEIGHT_LIMIT;
    found = 1'b0;
    sel   = '0;
    for (int p = 0; p < act_ports; p++) begin
      if ((dest & lt_mask[p]) != '0 && int'(lt_weight[p]) < best) begin
        best  = int'(lt_weight[p]);
        sel   = lahr_pkg::PORT_W'(p);
        found = 1'b1;
      end
    end
    if (!found) begin
      r.status = lahr_pkg::ST_NO_LOCAL;
      return r;
    end
    r.port = sel;

    n       = nt_count[sel];
    best    = lahr_pkg::WEIGHT_LIMIT;
    found_n = 1'b0;
    nsel    = '0;
    for (int e = 0; e < n; e++) begin
      if ((dest & nt_mask[sel][e]) != '0 && int'(nt_weight[sel][e]) < best) begin
        best    = int'(nt_weight[sel][e]);
        nsel    = lahr_pkg::ENTRY_W'(e);
        found_n = 1'b1;
      end
    end
    if (found_n) begin
      r.nport    = nsel;
      r.has_next = 1'b1;
    end else if (n != 0) begin
      // The port leads on to a router, but none of its entries reaches the
      // destination. A count of zero instead marks an end node and stays OK.
      r.status = lahr_pkg::ST_NO_NEXT;
    end
    return r;
  endfunction

  // Masks range from dense to single bits, so that routes sometimes meet
  // several ports, sometimes one, and sometimes none.
  function automatic logic [lahr_pkg::MASK_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4:       return '1;
      default: return ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
    endcase
  endfunction

  // Small weights give plenty of ties, and weights near the limit test the
  // cutoff.
  function automatic logic [lahr_pkg::WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 3))
      0:       return lahr_pkg::WEIGHT_W'($urandom_range(0, 15));
      1:       return lahr_pkg::WEIGHT_W'($urandom_range(lahr_pkg::WEIGHT_LIMIT - 5,
                                                          lahr_pkg::WEIGHT_LIMIT + 5));
      2:       return lahr_pkg::WEIGHT_W'($urandom_range(0, 16383));
      default: return '1;
    endcase
  endfunction

  task automatic queue_item(input logic [lahr_pkg::MODE_W-1:0] mode,
                            input int port,
                            input int entry,
                            input logic [lahr_pkg::MASK_W-1:0] mask,
                            input logic [lahr_pkg::WEIGHT_W-1:0] weight,
                            input int count);
    lahr_pkg::item_t it;
    it.mode   = mode;
    it.port   = lahr_pkg::PORT_W'(port);
    it.entry  = lahr_pkg::ENTRY_W'(entry);
    it.mask   = mask;
    it.weight = weight;
    it.count  = lahr_pkg::CNT_W'(count);
    it.vc     = lahr_pkg::VC_W'($urandom_range(0, 15));
    if (mode == lahr_pkg::MODE_LOCAL) local_loaded[port] = 1'b1;
    if (mode == lahr_pkg::MODE_NEXT) next_loaded[port][entry] = 1'b1;
    queued_items = {queued_items, it};
  endtask

  // Loads the missing next-hop entries below the count before the count itself.
  task automatic queue_count(input int port, input int count);
    int depth;
    depth = (count > lahr_pkg::NEXT_DEPTH) ? lahr_pkg::NEXT_DEPTH : count;
    for (int e = 0; e < depth; e++) begin
      if (!next_loaded[port][e]) begin
        queue_item(lahr_pkg::MODE_NEXT, port, e, random_mask(), random_weight(),
                   $urandom_range(0, 15));
      end
    end
    queue_item(lahr_pkg::MODE_COUNT, port, $urandom_range(0, 7), random_mask(),
               random_weight(), count);
  endtask

  // Loads any active local entry that is still missing before the route.
  task automatic queue_route(input logic [lahr_pkg::MASK_W-1:0] mask);
    for (int p = 0; p < gen_active; p++) begin
      if (!local_loaded[p]) begin
        queue_item(lahr_pkg::MODE_LOCAL, p, $urandom_range(0, 7), random_mask(),
                   random_weight(), $urandom_range(0, 15));
      end
    end
    queue_item(lahr_pkg::MODE_ROUTE, $urandom_range(0, 7), $urandom_range(0, 7), mask,
               random_weight(), $urandom_range(0, 15));
  endtask

  // Returns once no item waits, none is on the channel and no result is due.
  task automatic wait_for_drain();
    while (queued_items.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
      errors++;
    end
  endtask

  // Input driver. A new item goes out only once the channel is free, which
  // means the previous item has been transferred or nothing was offered.
  // When a burst runs out, a random gap follows, and about half the gaps are
  // empty so that back-to-back stretches occur as well.
  always @(posedge clk) begin : item_driver
    lahr_pkg::item_t it;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (queued_items.size() != 0) begin
        it = queued_items.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= it.mode;
        in_port_index  <= it.port;
        in_entry_index <= it.entry;
        in_dest_mask   <= it.mask;
        in_weight      <= it.weight;
        in_entry_count <= it.count;
        in_vc_tag      <= it.vc;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall pattern, chosen per phase: always ready, random stalls, or
  // a fixed repeating stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 8;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 99) >= 30);
        default: out_ready <= (stall_phase < 5);
      endcase
    end
  end

  // Monitor. All values are sampled at the clock edge, before the updates
  // driven at that edge take effect. A configuration write reaches the model
  // at the same edge at which the block takes it.
  always @(posedge clk) begin : result_checker
    lahr_pkg::item_t taken;
    route_result_t   got;
    route_result_t   want;
    if (rst_n) begin
      if (cfg_wr_en) act_ports = clamp_ports(cfg_wr_data);
      if (out_valid && out_ready) begin
        got.port     = out_out_port;
        got.nport    = out_next_port;
        got.has_next = out_has_next;
        got.vc       = out_vc_echo;
        got.status   = out_status;
        if (predicted_results.size() == 0) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: result transfer with no expected result, expected none, actual %h",
                     $time, got);
          end
          errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("out_port", 8'(want.port), 8'(got.port));
          check_field("next_port", 8'(want.nport), 8'(got.nport));
          check_field("has_next", 8'(want.has_next), 8'(got.has_next));
          check_field("vc_echo", 8'(want.vc), 8'(got.vc));
          check_field("status", 8'(want.status), 8'(got.status));
        end
      end
      if (in_valid && in_ready) begin
        taken.mode   = in_mode;
        taken.port   = in_port_index;
        taken.entry  = in_entry_index;
        taken.mask   = in_dest_mask;
        taken.weight = in_weight;
        taken.count  = in_entry_count;
        taken.vc     = in_vc_tag;
        predicted_results = {predicted_results, compute_route(taken)};
      end
    end
  end

  // Watchdog. The run ends when no transfer happens on either channel for
  // too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [lahr_pkg::CFG_W-1:0] cfg_plan [NUM_PHASES];
    int sel;
    for (int p = 0; p < lahr_pkg::NUM_PORTS; p++) begin
      nt_count[p]     = 0;
      local_loaded[p] = 1'b0;
      for (int e = 0; e < lahr_pkg::NEXT_DEPTH; e++) next_loaded[p][e] = 1'b0;
    end
    act_ports  = lahr_pkg::NUM_PORTS;
    gen_active = lahr_pkg::NUM_PORTS;

    // The phase settings include both ends of the range and values that
    // the block has to clamp.
    cfg_plan[0] = lahr_pkg::CFG_W'(lahr_pkg::NUM_PORTS);
    cfg_plan[1] = lahr_pkg::CFG_W'(1);
    cfg_plan[2] = lahr_pkg::CFG_W'(15);
    cfg_plan[3] = lahr_pkg::CFG_W'(0);
    cfg_plan[4] = lahr_pkg::CFG_W'(5);
    cfg_plan[5] = lahr_pkg::CFG_W'(9);
    for (int i = 6; i < NUM_PHASES; i++) begin
      cfg_plan[i] = lahr_pkg::CFG_W'($urandom_range(0, 15));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // active_ports changes only while the pipeline holds nothing.
      wait_for_drain();
      repeat (2) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cfg_plan[ph];
      gen_active  = clamp_ports(cfg_plan[ph]);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      stall_mode = ph % 3;

      if (ph == 0) begin
        // Directed tables. Port 0 matches everything, but its weight is too
        // high to ever be chosen. Ports 1 and 2 tie, and port 1 has to win.
        // Port 3 sits just below the weight limit and port 4 right at it.
        // Ports 5 and 6 have weight zero, and port 6 has an empty mask.
        queue_item(lahr_pkg::MODE_LOCAL, 0, 0, '1, '1, 0);
        queue_item(lahr_pkg::MODE_LOCAL, 1, 0, 64'hF0, 14'd5, 0);
        queue_item(lahr_pkg::MODE_LOCAL, 2, 0, 64'hF0, 14'd5, 0);
        queue_item(lahr_pkg::MODE_LOCAL, 3, 0, 64'h8000_0000_0000_0000,
                   14'(lahr_pkg::WEIGHT_LIMIT - 1), 0);
        queue_item(lahr_pkg::MODE_LOCAL, 4, 0, 64'h8000_0000_0000_0000,
                   14'(lahr_pkg::WEIGHT_LIMIT), 0);
        queue_item(lahr_pkg::MODE_LOCAL, 5, 0, 64'h0F, 14'd0, 0);
        queue_item(lahr_pkg::MODE_LOCAL, 6, 0, '0, 14'd0, 0);
        queue_item(lahr_pkg::MODE_LOCAL, 7, 0, 64'h100, 14'd20, 0);
        // Port 1 leads to a router with two tied entries. The only entry of
        // port 5 is at the weight limit, so it never matches.
        queue_item(lahr_pkg::MODE_NEXT, 1, 0, 64'h10, 14'd3, 0);
        queue_item(lahr_pkg::MODE_NEXT, 1, 1, 64'h10, 14'd3, 0);
        queue_count(1, 2);
        queue_item(lahr_pkg::MODE_NEXT, 5, 0, 64'h08, 14'(lahr_pkg::WEIGHT_LIMIT), 0);
        queue_count(5, 1);
        // A full next-hop route with a tie on the entry, then no next route
        // and an end-node port. Port 5 finds no entry, then comes a
        // destination that only the overweight port covers, then an empty
        // destination and finally all destinations at once.
        queue_route(64'h10);
        queue_route(64'h20);
        queue_route(64'h8000_0000_0000_0000);
        queue_route(64'h01);
        queue_route(64'h200);
        queue_route('0);
        queue_route('1);
        // A count above the table depth saturates to a full table.
        queue_count(7, 15);
        queue_route(64'h100);
      end

      // Random traffic. Routes dominate, and each one rides on tables that
      // the writes around it keep changing.
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          queue_route(random_mask());
        end else if (sel < 65) begin
          queue_item(lahr_pkg::MODE_LOCAL, $urandom_range(0, 7), $urandom_range(0, 7),
                     random_mask(), random_weight(), $urandom_range(0, 15));
        end else if (sel < 85) begin
          queue_item(lahr_pkg::MODE_NEXT, $urandom_range(0, 7), $urandom_range(0, 7),
                     random_mask(), random_weight(), $urandom_range(0, 15));
        end else begin
          queue_count($urandom_range(0, 7), $urandom_range(0, 15));
        end
      end
    end

    // Give the block time to show any result that it should not produce.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $display("%0t: results still missing at the end, expected 0, actual %0d",
               $time, predicted_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lahr_pkg.sv
rtl/lahr_ram.sv
rtl/lookahead_table_route_compute.sv
rtl/lahr_checker.sv
tb/lookahead_table_route_compute_tb.sv
